/* hdl/ffca_pkg.sv */
package ffca_pkg;

  localparam logic [15:0] END_MARK = 16'hfffc;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_NOFIT   = 2'd1;
  localparam logic [1:0] ST_NOTINS  = 2'd2;

  localparam logic REG_HEAP_START = 1'b0;
  localparam logic REG_HEAP_END   = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FORM,
    S_CHECK,
    S_RD,
    S_EVAL,
    S_FREE_PREVRD,
    S_FREE_NEXTRD,
    S_FREE_MERGE,
    S_FREE_PMERGE,
    S_OUT
  } state_e;

  typedef struct packed {
    logic        we;
    logic [15:0] waddr;
    logic [31:0] wdata;
    logic [15:0] raddr;
  } mem_req_t;

endpackage

/* hdl/first_fit_coalescing_allocator_top.sv */
// first-fit heap allocator with coalescing over one memory segment
// request channel s_axis: tdata = {byte_count, block_addr}, tuser = func
// (0 allocate, 1 free); one request is worked at a time
// result channel m_axis: tdata = {used_bytes, status, result_addr}
// config channel cfg: index 0 heap_start, 1 heap_end; write only while idle
// the free list lives in a header memory of SEG_BYTES/4 words, one read
// per cycle; each list entry visited passes through the check, read and
// evaluate states; a walk that ends without taking a header (failed
// allocate, any free) adds a last check, a free that is linked in adds the
// next-read, merge, previous-read and previous-merge states (only the last
// two at the list end), and the first request adds the heap forming pass
// a new request is taken only after the previous result transfer
// reset clears the list head, used counter and formed flag; the heap is
// formed from the register values at the first request
// when the receiver stalls the result is held and no request is taken
module first_fit_coalescing_allocator_top #(
  parameter int unsigned SEG_BYTES = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // block_addr, byte_count
  input  logic        s_axis_tuser,  // func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata   // result_addr, status, used_bytes, zero pad
);
  import ffca_pkg::*;

  logic [15:0] heap_start_q, heap_end_q;
  mem_req_t    mreq;
  logic [31:0] mrdata;
  logic [15:0] r_addr, r_used;
  logic [1:0]  r_st;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_start_q <= 16'd0;
      heap_end_q   <= 16'd50000;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_HEAP_START: heap_start_q <= cfg_data_i;
        REG_HEAP_END:   heap_end_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ffca_ctrl #(.SegBytes(SEG_BYTES)) u_ctrl (
    .clk_i, .rst_ni,
    .heap_start_i (heap_start_q),
    .heap_end_i   (heap_end_q),
    .req_valid_i  (s_axis_tvalid),
    .req_ready_o  (s_axis_tready),
    .func_i       (s_axis_tuser),
    .block_addr_i (s_axis_tdata[15:0]),
    .byte_count_i (s_axis_tdata[31:16]),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .result_addr_o(r_addr),
    .status_o     (r_st),
    .used_bytes_o (r_used),
    .mem_req_o    (mreq),
    .mem_rdata_i  (mrdata)
  );

  ffca_hdr_mem #(.SegBytes(SEG_BYTES)) u_mem (
    .clk_i,
    .req_i  (mreq),
    .rdata_o(mrdata)
  );

  assign m_axis_tdata = {6'd0, r_used, r_st, r_addr};

endmodule

/* hdl/ffca_hdr_mem.sv */
module ffca_hdr_mem #(
  parameter int unsigned SegBytes = 65536
) (
  input  logic              clk_i,
  input  ffca_pkg::mem_req_t req_i,
  output logic [31:0]       rdata_o
);
  import ffca_pkg::*;

  localparam int unsigned Words = SegBytes / 4;
  localparam int unsigned Aw = (Words > 1) ? $clog2(Words) : 1;

  logic [31:0] mem_q [Words];
  logic [Aw-1:0] wa;
  logic [Aw-1:0] ra;

  assign wa = req_i.waddr[Aw+1:2];
  assign ra = req_i.raddr[Aw+1:2];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[wa] <= req_i.wdata;
    end
    rdata_o <= mem_q[ra];
  end

endmodule

/* hdl/ffca_ctrl.sv */
module ffca_ctrl #(
  parameter int unsigned SegBytes = 65536
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [15:0]        heap_start_i,
  input  logic [15:0]        heap_end_i,
  input  logic               req_valid_i,
  output logic               req_ready_o,
  input  logic               func_i,
  input  logic [15:0]        block_addr_i,
  input  logic [15:0]        byte_count_i,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output logic [15:0]        result_addr_o,
  output logic [1:0]         status_o,
  output logic [15:0]        used_bytes_o,
  output ffca_pkg::mem_req_t mem_req_o,
  input  logic [31:0]        mem_rdata_i
);
  import ffca_pkg::*;

  localparam int unsigned WalkLimit = SegBytes / 4 + 1;
  localparam int unsigned Cw = $clog2(WalkLimit + 1);

  state_e state_q, state_d;
  logic        formed_q, formed_d;
  logic [15:0] head_q, head_d;
  logic [15:0] used_q, used_d;
  logic        func_q, func_d;
  logic [15:0] p_q, p_d;
  logic [16:0] asz_q, asz_d;
  logic [15:0] bp_q, bp_d;
  logic [15:0] prev_q, prev_d;
  logic [15:0] prevsz_q, prevsz_d;
  logic        have_prev_q, have_prev_d;
  logic [Cw-1:0] steps_q, steps_d;
  logic [15:0] psize_q, psize_d;
  logic [15:0] pnext_q, pnext_d;
  logic [15:0] res_q, res_d;
  logic [1:0]  st_q, st_d;

  logic [16:0] start_w, end_w, cnt_round;
  logic [15:0] rd_next, rd_size;
  logic [16:0] sum_a;
  logic [16:0] used_sum;

  assign rd_next = mem_rdata_i[31:16];
  assign rd_size = mem_rdata_i[15:0];
  assign start_w = ({1'b0, heap_start_i} + 17'd3) & ~17'd3;
  assign end_w   = {1'b0, heap_end_i} & ~17'd3;
  assign cnt_round = ({1'b0, byte_count_i} + 17'd3) & ~17'd3;
  assign used_sum = {1'b0, used_q} + asz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      formed_q <= 1'b0;
      head_q   <= END_MARK;
      used_q   <= '0;
    end else begin
      state_q  <= state_d;
      formed_q <= formed_d;
      head_q   <= head_d;
      used_q   <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q <= func_d;
    p_q <= p_d;
    asz_q <= asz_d;
    bp_q <= bp_d;
    prev_q <= prev_d;
    prevsz_q <= prevsz_d;
    have_prev_q <= have_prev_d;
    steps_q <= steps_d;
    psize_q <= psize_d;
    pnext_q <= pnext_d;
    res_q <= res_d;
    st_q <= st_d;
  end

  always_comb begin
    state_d = state_q;
    formed_d = formed_q;
    head_d = head_q;
    used_d = used_q;
    func_d = func_q;
    p_d = p_q;
    asz_d = asz_q;
    bp_d = bp_q;
    prev_d = prev_q;
    prevsz_d = prevsz_q;
    have_prev_d = have_prev_q;
    steps_d = steps_q;
    psize_d = psize_q;
    pnext_d = pnext_q;
    res_d = res_q;
    st_d = st_q;
    mem_req_o = '0;
    mem_req_o.raddr = bp_q;
    req_ready_o = 1'b0;
    res_valid_o = 1'b0;
    sum_a = '0;
    unique case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          func_d = func_i;
          p_d = block_addr_i & ~16'd3;
          asz_d = cnt_round;
          bp_d = head_q;
          have_prev_d = 1'b0;
          prev_d = '0;
          steps_d = '0;
          res_d = '0;
          state_d = formed_q ? S_CHECK : S_FORM;
        end
      end
      S_FORM: begin
        formed_d = 1'b1;
        used_d = start_w[16] ? 16'hffff : start_w[15:0];
        if (start_w < end_w) begin
          head_d = start_w[15:0];
          bp_d = start_w[15:0];
          mem_req_o.we = 1'b1;
          mem_req_o.waddr = start_w[15:0];
          mem_req_o.wdata = {END_MARK, 16'(end_w - start_w)};
        end else begin
          head_d = END_MARK;
          bp_d = END_MARK;
        end
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (func_q == FUNC_ALLOC) begin
          if (asz_q == '0 || bp_q == END_MARK || steps_q >= Cw'(WalkLimit)) begin
            st_d = ST_NOFIT;
            state_d = S_OUT;
          end else begin
            state_d = S_RD;
          end
        end else begin
          if (asz_q == '0) begin
            st_d = ST_DONE;
            state_d = S_OUT;
          end else if (steps_q >= Cw'(WalkLimit)) begin
            st_d = ST_NOTINS;
            used_d = (asz_q >= {1'b0, used_q}) ? '0 : 16'(used_sum - 2*asz_q);
            state_d = S_OUT;
          end else if (p_q < bp_q) begin
            psize_d = asz_q[16] ? 16'hffff : asz_q[15:0];
            mem_req_o.we = 1'b1;
            mem_req_o.waddr = p_q;
            mem_req_o.wdata = {bp_q, psize_d};
            if (!have_prev_q) head_d = p_q;
            state_d = (bp_q != END_MARK) ? S_FREE_NEXTRD : S_FREE_PREVRD;
            mem_req_o.raddr = bp_q;
          end else if (bp_q == END_MARK) begin
            st_d = ST_NOTINS;
            used_d = (asz_q >= {1'b0, used_q}) ? '0 : 16'(used_sum - 2*asz_q);
            state_d = S_OUT;
          end else begin
            state_d = S_RD;
          end
        end
      end
      S_RD: begin
        state_d = S_EVAL;
      end
      S_EVAL: begin
        if (func_q == FUNC_ALLOC) begin
          if ({1'b0, rd_size} >= asz_q) begin
            if ({1'b0, rd_size} == asz_q) begin
              if (have_prev_q) begin
                mem_req_o.we = 1'b1;
                mem_req_o.waddr = prev_q;
                mem_req_o.wdata = {rd_next, prevsz_q};
              end else begin
                head_d = rd_next;
              end
              res_d = bp_q;
            end else begin
              res_d = 16'({1'b0, bp_q} + {1'b0, rd_size} - asz_q);
              mem_req_o.we = 1'b1;
              mem_req_o.waddr = bp_q;
              mem_req_o.wdata = {rd_next, 16'({1'b0, rd_size} - asz_q)};
            end
            used_d = used_sum[16] ? 16'hffff : used_sum[15:0];
            st_d = ST_DONE;
            state_d = S_OUT;
          end else begin
            prev_d = bp_q;
            prevsz_d = rd_size;
            have_prev_d = 1'b1;
            bp_d = rd_next;
            steps_d = steps_q + 1'b1;
            state_d = S_CHECK;
          end
        end else begin
          prev_d = bp_q;
          prevsz_d = rd_size;
          have_prev_d = 1'b1;
          bp_d = rd_next;
          steps_d = steps_q + 1'b1;
          state_d = S_CHECK;
        end
      end
      S_FREE_NEXTRD: begin
        // link the previous entry before the next merge may rewrite the same header
        if (have_prev_q) begin
          mem_req_o.we = 1'b1;
          mem_req_o.waddr = prev_q;
          mem_req_o.wdata = {p_q, (prev_q == p_q) ? psize_q : prevsz_q};
        end
        state_d = S_FREE_MERGE;
      end
      S_FREE_MERGE: begin
        pnext_d = bp_q;
        if (17'({1'b0, p_q} + {1'b0, psize_q}) == {1'b0, bp_q}) begin
          sum_a = {1'b0, psize_q} + {1'b0, rd_size};
          psize_d = sum_a[16] ? 16'hffff : sum_a[15:0];
          pnext_d = rd_next;
          mem_req_o.we = 1'b1;
          mem_req_o.waddr = p_q;
          mem_req_o.wdata = {rd_next, psize_d};
        end
        state_d = S_FREE_PREVRD;
      end
      S_FREE_PREVRD: begin
        if (state_q == S_FREE_PREVRD && bp_q == END_MARK && pnext_q != END_MARK) begin
          pnext_d = END_MARK;
        end
        if (have_prev_q && bp_q == END_MARK) begin
          mem_req_o.we = 1'b1;
          mem_req_o.waddr = prev_q;
          mem_req_o.wdata = {p_q, (prev_q == p_q) ? psize_q : prevsz_q};
        end
        state_d = S_FREE_PMERGE;
      end
      S_FREE_PMERGE: begin
        if (have_prev_q && 17'({1'b0, prev_q} + {1'b0, prevsz_q}) == {1'b0, p_q}) begin
          sum_a = {1'b0, prevsz_q} + {1'b0, psize_q};
          mem_req_o.we = 1'b1;
          mem_req_o.waddr = prev_q;
          mem_req_o.wdata = {pnext_q, sum_a[16] ? 16'hffff : sum_a[15:0]};
        end
        st_d = ST_DONE;
        used_d = (asz_q >= {1'b0, used_q}) ? '0 : 16'(used_sum - 2*asz_q);
        state_d = S_OUT;
      end
      S_OUT: begin
        res_valid_o = 1'b1;
        if (res_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
    if (state_q == S_CHECK && func_q == FUNC_FREE && p_q < bp_q && bp_q == END_MARK) begin
      pnext_d = END_MARK;
    end
  end

  assign result_addr_o = (st_q == ST_DONE) ? res_q : '0;
  assign status_o = st_q;
  assign used_bytes_o = used_q;

endmodule
